// ----- rtl/vckd_pkg.sv -----
// Package with the shared types and constants of the key debounce unit.
`timescale 1ns / 1ps

package vckd_pkg;

   localparam int KEY_COUNT = 8;
   localparam int TICK_WIDTH = 8;

   localparam logic [KEY_COUNT-1:0] KEY_ALL = 8'hFF;
   localparam logic [TICK_WIDTH-1:0] START_TICKS_RESET = 8'd50;
   localparam logic [TICK_WIDTH-1:0] NEXT_TICKS_RESET = 8'd20;

   typedef logic [KEY_COUNT-1:0] keys_type;
   typedef logic [TICK_WIDTH-1:0] ticks_type;

   // Request kinds carried on the request tuser field.
   typedef enum logic [2:0] {
      REQ_SAMPLE = 3'd0,
      REQ_PRESS  = 3'd1,
      REQ_REPEAT = 3'd2,
      REQ_STATE  = 3'd3,
      REQ_SHORT  = 3'd4,
      REQ_LONG   = 3'd5
   } req_kind_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_INVERT_MASK  = 2'd0,
      CSR_REPEAT_EN    = 2'd1,
      CSR_START_TICKS  = 2'd2,
      CSR_NEXT_TICKS   = 2'd3
   } csr_index_type;

   typedef struct packed {
      keys_type  invert_mask;
      keys_type  repeat_enable_mask;
      ticks_type repeat_start_ticks;
      ticks_type repeat_next_ticks;
   } cfg_type;

   typedef struct packed {
      logic [2:0] req_type;
      keys_type   raw_keys;
      keys_type   query_mask;
   } cmd_type;

endpackage

// ----- rtl/vckd_csr.sv -----
// Configuration registers of the key debounce unit.
`timescale 1ns / 1ps

module vckd_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_data,
   output logic                  csr_ready,
   output vckd_pkg::cfg_type     cfg
);

   vckd_pkg::cfg_type cfg_ff;
   vckd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (vckd_pkg::csr_index_type'(csr_index))
            vckd_pkg::CSR_INVERT_MASK: cfg_in.invert_mask = csr_data;
            vckd_pkg::CSR_REPEAT_EN:   cfg_in.repeat_enable_mask = csr_data;
            vckd_pkg::CSR_START_TICKS: cfg_in.repeat_start_ticks = csr_data;
            vckd_pkg::CSR_NEXT_TICKS:  cfg_in.repeat_next_ticks = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.invert_mask <= '0;
         cfg_ff.repeat_enable_mask <= '0;
         cfg_ff.repeat_start_ticks <= vckd_pkg::START_TICKS_RESET;
         cfg_ff.repeat_next_ticks <= vckd_pkg::NEXT_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/vckd_kernel.sv -----
// Debounce state, latches and repeat countdown, updated once per request.
`timescale 1ns / 1ps

module vckd_kernel (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  vckd_pkg::cmd_type     cmd,
   input  vckd_pkg::cfg_type     cfg,
   output vckd_pkg::keys_type    answer
);

   vckd_pkg::keys_type  state_ff, state_in;
   vckd_pkg::keys_type  press_ff, press_in;
   vckd_pkg::keys_type  repeat_ff, repeat_in;
   vckd_pkg::keys_type  cnt_low_ff, cnt_low_in;
   vckd_pkg::keys_type  cnt_high_ff, cnt_high_in;
   vckd_pkg::ticks_type countdown_ff, countdown_in;

   vckd_pkg::keys_type  diff;
   vckd_pkg::keys_type  low_next;
   vckd_pkg::keys_type  high_next;
   vckd_pkg::keys_type  flip;
   vckd_pkg::keys_type  state_next;
   vckd_pkg::keys_type  held_repeat;
   vckd_pkg::ticks_type count_base;
   vckd_pkg::ticks_type count_dec;
   vckd_pkg::keys_type  press_hit;
   vckd_pkg::keys_type  repeat_hit;
   vckd_pkg::keys_type  short_mask;

   // Two-bit vertical counters: a key flips after four disagreeing samples.
   always_comb begin
      diff = state_ff ^ (cmd.raw_keys ^ cfg.invert_mask);
      low_next = ~(cnt_low_ff & diff) & vckd_pkg::KEY_ALL;
      high_next = low_next ^ (cnt_high_ff & diff);
      flip = diff & low_next & high_next;
      state_next = state_ff ^ flip;
      held_repeat = state_next & cfg.repeat_enable_mask;
      count_base = (held_repeat == '0) ? cfg.repeat_start_ticks : countdown_ff;
      count_dec = count_base - 8'd1;
      repeat_hit = cmd.query_mask & repeat_ff;
      short_mask = ~state_ff & cmd.query_mask;
      press_hit = cmd.query_mask & press_ff;
   end

   always_comb begin
      state_in = state_ff;
      press_in = press_ff;
      repeat_in = repeat_ff;
      cnt_low_in = cnt_low_ff;
      cnt_high_in = cnt_high_ff;
      countdown_in = countdown_ff;
      answer = '0;
      unique case (cmd.req_type)
         vckd_pkg::REQ_SAMPLE: begin
            cnt_low_in = low_next;
            cnt_high_in = high_next;
            state_in = state_next;
            press_in = press_ff | (state_next & flip);
            if (count_dec == '0) begin
               countdown_in = cfg.repeat_next_ticks;
               repeat_in = repeat_ff | held_repeat;
            end else begin
               countdown_in = count_dec;
            end
            answer = state_next;
         end
         vckd_pkg::REQ_PRESS: begin
            answer = press_hit;
            press_in = press_ff ^ press_hit;
         end
         vckd_pkg::REQ_REPEAT: begin
            answer = repeat_hit;
            repeat_in = repeat_ff ^ repeat_hit;
         end
         vckd_pkg::REQ_STATE: begin
            answer = cmd.query_mask & state_ff;
         end
         vckd_pkg::REQ_SHORT: begin
            answer = short_mask & press_ff;
            press_in = press_ff ^ (short_mask & press_ff);
         end
         vckd_pkg::REQ_LONG: begin
            // Repeat bits taken here select which press bits are taken.
            repeat_in = repeat_ff ^ repeat_hit;
            answer = repeat_hit & press_ff;
            press_in = press_ff ^ (repeat_hit & press_ff);
         end
         default: answer = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         press_ff <= '0;
         repeat_ff <= '0;
         cnt_low_ff <= vckd_pkg::KEY_ALL;
         cnt_high_ff <= vckd_pkg::KEY_ALL;
         countdown_ff <= '0;
      end else if (enable) begin
         state_ff <= state_in;
         press_ff <= press_in;
         repeat_ff <= repeat_in;
         cnt_low_ff <= cnt_low_in;
         cnt_high_ff <= cnt_high_in;
         countdown_ff <= countdown_in;
      end
   end

endmodule

// ----- rtl/vertical_counter_key_debounce_unit.sv -----
// Top level of the eight-key debounce unit with auto-repeat.
//
//   channel  direction  payload
//   req      in         tuser: req_type[2:0]; tdata: raw_keys[7:0], query_mask[15:8]
//   rsp      out        tdata: key_bits[7:0]
//   csr      in         index[1:0] selects the register, data[7:0] is the value
//
// Each request is registered on accept, processed against the key state once
// the response register can take it, and the result is placed in the response
// register. One request is taken every cycle
// while responses drain; the response register is the only stall point.
// Reset is synchronous; it clears the key state, the latches and both
// valid flags and loads the configuration reset values.
`timescale 1ns / 1ps

module vertical_counter_key_debounce_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // raw_keys[7:0], query_mask[15:8]
   input  logic [2:0]  req_tuser,   // req_type[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // key_bits[7:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   vckd_pkg::cfg_type  cfg;
   vckd_pkg::cmd_type  cmd_ff, cmd_in;
   logic               cmd_valid_ff, cmd_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   vckd_pkg::keys_type rsp_data_ff, rsp_data_in;
   vckd_pkg::keys_type answer;
   logic               advance;
   logic               req_take;

   vckd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   vckd_kernel u_kernel (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .cmd    (cmd_ff),
      .cfg    (cfg),
      .answer (answer)
   );

   // The request register moves on whenever the response register can take it.
   assign advance = cmd_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !cmd_valid_ff || advance;
   assign req_take = req_tvalid && req_tready;

   always_comb begin
      cmd_in = cmd_ff;
      if (req_take) begin
         cmd_in.req_type = req_tuser;
         cmd_in.raw_keys = req_tdata[7:0];
         cmd_in.query_mask = req_tdata[15:8];
      end
      cmd_valid_in = req_take || (cmd_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
      rsp_data_in = advance ? answer : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("request stalled while the response register is empty");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_take |=> cmd_valid_ff)
      else $error("accepted request was not registered");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed request produced no response");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !cmd_valid_ff))
      else $error("valid flags not cleared by reset");

endmodule
